[src/bblur_pkg.sv]
// Shared constants, types and the reciprocal table of the 3x3 box blur.
package bblur_pkg;

	// Frame geometry limits
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;

	// Position counter widths; the input row runs up to two past the last row
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int OROW_W = $clog2(MAX_HEIGHT);
	localparam int ROW_W  = OROW_W + 1;

	// Configuration registers
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 13;
	localparam int WREG_W      = 11;
	localparam int HREG_W      = 13;

	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

	localparam logic [WREG_W-1:0] WIDTH_RESET  = 11'd640;
	localparam logic [HREG_W-1:0] HEIGHT_RESET = 13'd480;

	// Pixel and arithmetic widths
	localparam int CH_W        = 8;
	localparam int PIX_W       = 3 * CH_W;
	localparam int SUM_W       = 12;
	localparam int CNT_W       = 4;
	localparam int RECIP_W     = 19;
	localparam int RECIP_SHIFT = 18;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_DIV  = 3'b100
	} state_t;

	// Which neighbours of the output pixel lie inside the image
	typedef struct packed {
		logic row_above;
		logic row_below;
		logic col_left;
		logic col_right;
	} nbr_mask_t;

	// ceil(2^RECIP_SHIFT / n); exact quotient for dividends below 4096
	function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
		logic [RECIP_W-1:0] m;
		unique case (n)
			4'd1:    m = 19'd262144;
			4'd2:    m = 19'd131072;
			4'd3:    m = 19'd87382;
			4'd4:    m = 19'd65536;
			4'd5:    m = 19'd52429;
			4'd6:    m = 19'd43691;
			4'd7:    m = 19'd37450;
			4'd8:    m = 19'd32768;
			4'd9:    m = 19'd29128;
			default: m = 19'd262144;
		endcase
		return m;
	endfunction

endpackage

[src/box_blur_3x3_rgb_unit.sv]
// Streaming 3x3 box blur over RGB pixels: top level with line stores and window.
//
// Pixels arrive in raster order; each result is the rounded mean of the in-image
// pixels of a 3x3 neighbourhood, so the result for position q leaves with input
// position q + width + 1, and width + 1 drain items (mode 1) after the last pixel
// of a frame flush the tail; frame_last marks the final result. A drain item that
// arrives inside the frame is dropped. Any other item goes through the line-store
// read, then the window update and the neighbourhood sums, and, when it gives a
// result, the reciprocal-multiply divide into the output register. A result held
// by out_stall does not block the next transfer in, but the divide stage waits
// for the output register. The line stores are not cleared after reset: entries
// outside the current frame never reach a result. Any register write starts a
// new frame.
module box_blur_3x3_rgb_unit
	import bblur_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	// input channel
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   mode,
	input  logic [CH_W-1:0]        red_in,
	input  logic [CH_W-1:0]        green_in,
	input  logic [CH_W-1:0]        blue_in,
	// output channel
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [CH_W-1:0]        red_out,
	output logic [CH_W-1:0]        green_out,
	output logic [CH_W-1:0]        blue_out,
	output logic                   frame_last
);

	state_t state_q;

	logic [WREG_W-1:0] width_q;
	logic [HREG_W-1:0] height_q;
	logic [WREG_W-1:0] w_eff;
	logic [HREG_W-1:0] h_eff;

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  ocol_q;
	logic [OROW_W-1:0] orow_q;

	logic              accept;
	logic              drain;
	logic              take;
	logic              emit;
	logic              last;
	logic [WREG_W-1:0] col_inc;
	logic              col_wrap;
	logic [WREG_W-1:0] ocol_inc;
	logic [HREG_W-1:0] orow_inc;
	nbr_mask_t         mask;

	logic [PIX_W-1:0]  px_s1;
	logic [COL_W-1:0]  col_s1;
	logic              emit_s1;
	logic              last_s1;
	nbr_mask_t         mask_s1;

	logic [PIX_W-1:0]  top_rd;
	logic [PIX_W-1:0]  mid_rd;
	logic              store_we;

	logic [PIX_W-1:0]  win_q [3][3];
	logic [PIX_W-1:0]  win_d [3][3];
	logic [2:0]        inc_row;
	logic [2:0]        inc_col;
	logic [SUM_W-1:0]  sum_r;
	logic [SUM_W-1:0]  sum_g;
	logic [SUM_W-1:0]  sum_b;
	logic [CNT_W-1:0]  cnt;

	logic [SUM_W-1:0]  sum_r_s2;
	logic [SUM_W-1:0]  sum_g_s2;
	logic [SUM_W-1:0]  sum_b_s2;
	logic [CNT_W-1:0]  cnt_s2;
	logic              last_s2;

	logic [CH_W-1:0]   mean_r;
	logic [CH_W-1:0]   mean_g;
	logic [CH_W-1:0]   mean_b;
	logic              out_load;

	logic              out_valid_q;
	logic [CH_W-1:0]   red_q;
	logic [CH_W-1:0]   green_q;
	logic [CH_W-1:0]   blue_q;
	logic              frame_last_q;

	// Clamp the frame geometry to 1..MAX
	always_comb begin
		priority if (width_q == '0) begin
			w_eff = WREG_W'(1);
		end else if (width_q > WREG_W'(MAX_WIDTH)) begin
			w_eff = WREG_W'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		priority if (height_q == '0) begin
			h_eff = HREG_W'(1);
		end else if (height_q > HREG_W'(MAX_HEIGHT)) begin
			h_eff = HREG_W'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
	end

	// Decode the incoming transfer against the position counters
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign drain    = (ROW_W'(row_q) >= ROW_W'(h_eff));
	assign take     = accept && (drain || !mode);
	assign emit     = (row_q >= ROW_W'(2)) || ((row_q == ROW_W'(1)) && (col_q != '0));
	assign col_inc  = WREG_W'(col_q) + WREG_W'(1);
	assign col_wrap = (col_inc >= w_eff);
	assign ocol_inc = WREG_W'(ocol_q) + WREG_W'(1);
	assign orow_inc = HREG_W'(orow_q) + HREG_W'(1);
	assign last     = emit && (ocol_inc == w_eff) && (orow_inc == h_eff);

	always_comb begin
		mask.row_above = (orow_q != '0);
		mask.row_below = (orow_inc < h_eff);
		mask.col_left  = (ocol_q != '0);
		mask.col_right = (ocol_inc < w_eff);
	end

	// Configuration registers and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			col_q    <= '0;
			row_q    <= '0;
			ocol_q   <= '0;
			orow_q   <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[WREG_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[HREG_W-1:0];
				default: ;
			endcase
			col_q  <= '0;
			row_q  <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (take) begin
			if (last) begin
				col_q  <= '0;
				row_q  <= '0;
				ocol_q <= '0;
				orow_q <= '0;
			end else begin
				if (col_wrap) begin
					col_q <= '0;
					row_q <= row_q + ROW_W'(1);
				end else begin
					col_q <= col_inc[COL_W-1:0];
				end
				if (emit) begin
					if (ocol_inc == w_eff) begin
						ocol_q <= '0;
						orow_q <= orow_q + OROW_W'(1);
					end else begin
						ocol_q <= ocol_inc[COL_W-1:0];
					end
				end
			end
		end
	end

	// Capture the transfer for the read stage
	always_ff @(posedge clk) begin
		if (take) begin
			px_s1   <= drain ? '0 : {red_in, green_in, blue_in};
			col_s1  <= col_q;
			emit_s1 <= emit;
			last_s1 <= last;
			mask_s1 <= mask;
		end
	end

	// Line stores: store_a holds the row above, store_b the row above that
	assign store_we = (state_q == ST_READ);

	bblur_ram #(
		.WIDTH(PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_store_a (
		.clk  (clk),
		.we   (store_we),
		.waddr(col_s1),
		.wdata(px_s1),
		.re   (take),
		.raddr(col_q),
		.rdata(mid_rd)
	);

	bblur_ram #(
		.WIDTH(PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_store_b (
		.clk  (clk),
		.we   (store_we),
		.waddr(col_s1),
		.wdata(mid_rd),
		.re   (take),
		.raddr(col_q),
		.rdata(top_rd)
	);

	// Shift the window left and sum the in-image neighbours
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			win_d[i][0] = win_q[i][1];
			win_d[i][1] = win_q[i][2];
		end
		win_d[0][2] = top_rd;
		win_d[1][2] = mid_rd;
		win_d[2][2] = px_s1;

		inc_row = {mask_s1.row_below, 1'b1, mask_s1.row_above};
		inc_col = {mask_s1.col_right, 1'b1, mask_s1.col_left};

		sum_r = '0;
		sum_g = '0;
		sum_b = '0;
		cnt   = '0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (inc_row[i] && inc_col[j]) begin
					sum_r = sum_r + SUM_W'(win_d[i][j][2*CH_W +: CH_W]);
					sum_g = sum_g + SUM_W'(win_d[i][j][CH_W +: CH_W]);
					sum_b = sum_b + SUM_W'(win_d[i][j][0 +: CH_W]);
					cnt   = cnt + CNT_W'(1);
				end
			end
		end
	end

	// Hold the window between items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (state_q == ST_READ) begin
			win_q <= win_d;
		end
	end

	// Register the sums for the divide stage
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			sum_r_s2 <= sum_r;
			sum_g_s2 <= sum_g;
			sum_b_s2 <= sum_b;
			cnt_s2   <= cnt;
			last_s2  <= last_s1;
		end
	end

	// Per-channel rounded mean
	bblur_mean u_mean_red (
		.sum  (sum_r_s2),
		.count(cnt_s2),
		.mean (mean_r)
	);

	bblur_mean u_mean_green (
		.sum  (sum_g_s2),
		.count(cnt_s2),
		.mean (mean_g)
	);

	bblur_mean u_mean_blue (
		.sum  (sum_b_s2),
		.count(cnt_s2),
		.mean (mean_b)
	);

	assign out_load = (state_q == ST_DIV) && (!out_valid_q || !out_stall);

	// Sequencer: accept, read and sum, divide into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= emit_s1 ? ST_DIV : ST_IDLE;
				end
				ST_DIV: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register: load on a finished divide, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			red_q        <= mean_r;
			green_q      <= mean_g;
			blue_q       <= mean_b;
			frame_last_q <= last_s2;
		end
	end

	assign out_valid  = out_valid_q;
	assign red_out    = red_q;
	assign green_out  = green_q;
	assign blue_out   = blue_q;
	assign frame_last = frame_last_q;

	// A new result appears only out of the divide stage
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DIV))
		else $error("output valid rose without a divide stage");

	// The read stage always follows a taken transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> $past(take))
		else $error("read stage entered without a transfer");

	// The divide sees between one and nine neighbours
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (cnt_s2 != '0) && (cnt_s2 <= CNT_W'(9)))
		else $error("neighbour count out of range");

	// The input and output columns stay inside the row
	assert property (@(posedge clk) disable iff (!arst_n)
		(WREG_W'(col_q) < w_eff) && (WREG_W'(ocol_q) < w_eff))
		else $error("column counter beyond the row width");

endmodule

[src/bblur_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module bblur_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[src/bblur_mean.sv]
// Rounded mean of one channel: (2*sum + n) / (2*n) by reciprocal multiply.
module bblur_mean
	import bblur_pkg::*;
(
	input  logic [SUM_W-1:0] sum,
	input  logic [CNT_W-1:0] count,
	output logic [CH_W-1:0]  mean
);

	logic [SUM_W-1:0]         dividend;
	logic [SUM_W+RECIP_W-1:0] prod;

	// Fold the half-up rounding into the dividend: floor((sum + n/2) / n)
	assign dividend = sum + SUM_W'(count >> 1);

	// Multiply by the scaled reciprocal and keep the integer part
	assign prod = (SUM_W + RECIP_W)'(dividend) * (SUM_W + RECIP_W)'(recip(count));
	assign mean = prod[RECIP_SHIFT +: CH_W];

endmodule

[verif/box_blur_3x3_rgb_unit_tb.sv]
// Self-checking testbench of the streaming 3x3 RGB box blur, with its own pixel predictor.
`timescale 1ns / 100ps

module box_blur_3x3_rgb_unit_tb
	import bblur_pkg::*;
();

	// One output pixel as the block presents it
	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            last;
	} blur_pix_t;

	// One row of the directed table: a geometry load or a pixel transfer
	typedef struct packed {
		logic            is_cfg;
		logic [12:0]     wv;
		logic [12:0]     hv;
		logic            m;
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
		logic            typed;
		blur_pix_t       res;
	} step_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic                   mode = 1'b0;
	logic [CH_W-1:0]        red_in = '0;
	logic [CH_W-1:0]        green_in = '0;
	logic [CH_W-1:0]        blue_in = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [CH_W-1:0]        red_out;
	logic [CH_W-1:0]        green_out;
	logic [CH_W-1:0]        blue_out;
	logic                   frame_last;

	box_blur_3x3_rgb_unit i_dut (.*);

	always #5 clk = ~clk;

	// Predictor state: geometry registers, line stores, window, positions
	logic [WREG_W-1:0] geo_width;
	logic [HREG_W-1:0] geo_height;
	logic [PIX_W-1:0]  row_above [MAX_WIDTH];
	logic [PIX_W-1:0]  row_prev [MAX_WIDTH];
	logic [PIX_W-1:0]  win [3][3];
	int unsigned       at_col, at_row, out_pos;

	blur_pix_t   blurred_q[$];
	step_row_t   dir_tbl[$];
	int unsigned fails = 0;
	bit          calm = 0;
	bit          hold_req = 0;

	function automatic int unsigned frame_width(input logic [WREG_W-1:0] v);
		if (v == 0) return 1;
		if (v > MAX_WIDTH) return MAX_WIDTH;
		return v;
	endfunction

	function automatic int unsigned frame_height(input logic [HREG_W-1:0] v);
		if (v == 0) return 1;
		if (v > MAX_HEIGHT) return MAX_HEIGHT;
		return v;
	endfunction

	function automatic logic [CH_W-1:0] rounded_mean(input int unsigned s, input int unsigned n);
		return CH_W'((2 * s + n) / (2 * n));
	endfunction

	// Advance the predictor by one accepted item; return 1 when it yields a pixel
	function automatic bit blur_step(input logic m, input logic [CH_W-1:0] r, g, b,
			output blur_pix_t res);
		int unsigned      w, h, c, q, orow, ocol, n, sr, sg, sb;
		logic [PIX_W-1:0] px, top, mid, p;
		bit               emit;
		w = frame_width(geo_width);
		h = frame_height(geo_height);
		px = '0;
		res = '0;
		if (at_row < h) begin
			// drop a drain tick that comes before the frame is complete
			if (m) return 0;
			px = {r, g, b};
		end
		c = at_col;
		top = row_above[c];
		mid = row_prev[c];
		row_above[c] = mid;
		row_prev[c] = px;
		for (int i = 0; i < 3; i++) begin
			win[i][0] = win[i][1];
			win[i][1] = win[i][2];
		end
		win[0][2] = top;
		win[1][2] = mid;
		win[2][2] = px;
		emit = (at_row >= 2) || (at_row == 1 && c >= 1);
		at_col = c + 1;
		if (at_col >= w) begin
			at_col = 0;
			at_row = at_row + 1;
		end
		if (!emit) return 0;
		q = out_pos;
		orow = q / w;
		ocol = q % w;
		n = 0; sr = 0; sg = 0; sb = 0;
		for (int i = 0; i < 3; i++) begin
			if (i == 0 && orow == 0) continue;
			if (i == 2 && orow + 1 >= h) continue;
			for (int j = 0; j < 3; j++) begin
				if (j == 0 && ocol == 0) continue;
				if (j == 2 && ocol + 1 >= w) continue;
				p = win[i][j];
				sr += p[23:16];
				sg += p[15:8];
				sb += p[7:0];
				n++;
			end
		end
		res.red = rounded_mean(sr, n);
		res.green = rounded_mean(sg, n);
		res.blue = rounded_mean(sb, n);
		out_pos = q + 1;
		if (q + 1 >= w * h) begin
			res.last = 1'b1;
			at_col = 0;
			at_row = 0;
			out_pos = 0;
		end
		return 1;
	endfunction

	function automatic step_row_t cfg_row(input logic [12:0] wv, hv);
		step_row_t s;
		s = '0;
		s.is_cfg = 1'b1;
		s.wv = wv;
		s.hv = hv;
		return s;
	endfunction

	function automatic step_row_t pix_row(input logic m, input logic [CH_W-1:0] r, g, b);
		step_row_t s;
		s = '0;
		s.m = m;
		s.r = r;
		s.g = g;
		s.b = b;
		return s;
	endfunction

	function automatic step_row_t known_row(input logic m, input logic [CH_W-1:0] r, g, b,
			input logic [CH_W-1:0] er, eg, eb, input logic el);
		step_row_t s;
		s = pix_row(m, r, g, b);
		s.typed = 1'b1;
		s.res = '{er, eg, eb, el};
		return s;
	endfunction

	// Mostly random channel values, with the extremes weighted in
	function automatic logic [CH_W-1:0] rand_chan();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			default: return CH_W'($urandom_range(0, 255));
		endcase
	endfunction

	// Offer one item, wait for its transfer, then record what it should produce
	task automatic offer(input logic m, input logic [CH_W-1:0] r, g, b,
			input bit typed, input blur_pix_t typed_res);
		blur_pix_t res;
		bit        got;
		if (!calm && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		red_in <= r;
		green_in <= g;
		blue_in <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		got = blur_step(m, r, g, b, res);
		if (typed)
			blurred_q.push_back(typed_res);
		else if (got)
			blurred_q.push_back(res);
	endtask

	// Hold the input until every expected pixel is out and the pipeline is empty
	task automatic settle();
		in_valid <= 1'b0;
		while (blurred_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// Load both geometry registers while idle; any write starts a new frame
	task automatic load_geometry(input logic [12:0] wv, hv);
		settle();
		cfg_write <= 1'b1;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data <= wv;
		@(posedge clk);
		cfg_index <= REG_IMAGE_HEIGHT;
		cfg_data <= hv;
		@(posedge clk);
		cfg_write <= 1'b0;
		geo_width = wv[WREG_W-1:0];
		geo_height = hv;
		at_col = 0;
		at_row = 0;
		out_pos = 0;
	endtask

	task automatic check_field(input string name, input logic [CH_W-1:0] want, got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			fails++;
		end
	endtask

	// Receiver: check each transfer out, stall in random bursts and once for long
	initial begin : receiver
		blur_pix_t   want;
		int unsigned stall_left;
		bit          hold_done;
		stall_left = 0;
		hold_done = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (blurred_q.size() == 0) begin
					$display("%0t: unexpected pixel, expected none, got %0d %0d %0d last %0b",
						$time, red_out, green_out, blue_out, frame_last);
					fails++;
				end else begin
					want = blurred_q.pop_front();
					check_field("red", want.red, red_out);
					check_field("green", want.green, green_out);
					check_field("blue", want.blue, blue_out);
					check_field("frame_last", CH_W'(want.last), CH_W'(frame_last));
				end
			end
			if (stall_left != 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (hold_req && !hold_done) begin
				hold_done = 1;
				stall_left = 399;
				out_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 11) == 0) begin
				stall_left = $urandom_range(1, 18) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Give up on a hung run
	initial begin : watchdog
		#10_000_000;
		$display("box_blur_3x3_rgb_unit_tb NOT OK");
		$finish;
	end

	initial begin : sender
		int unsigned frame_no, plain_items, fw, fh, npix, cut;
		logic [12:0] wv, hv;
		bit          redo, abort, special;
		geo_width = WIDTH_RESET;
		geo_height = HEIGHT_RESET;
		foreach (row_above[i]) row_above[i] = '0;
		foreach (row_prev[i]) row_prev[i] = '0;
		foreach (win[i, j]) win[i][j] = '0;
		at_col = 0;
		at_row = 0;
		out_pos = 0;

		// single-pixel frame; a pixel after the frame acts as a drain tick
		dir_tbl.push_back(cfg_row(13'd0, 13'd0));
		dir_tbl.push_back(pix_row(1'b0, 8'd255, 8'd0, 8'd128));
		dir_tbl.push_back(pix_row(1'b1, 8'd0, 8'd0, 8'd0));
		dir_tbl.push_back(known_row(1'b0, 8'd17, 8'd34, 8'd51, 8'd255, 8'd0, 8'd128, 1'b1));
		// two pixels in a row: halves round up; a drain inside the frame is dropped
		dir_tbl.push_back(cfg_row(13'd2, 13'd1));
		dir_tbl.push_back(pix_row(1'b0, 8'd255, 8'd255, 8'd255));
		dir_tbl.push_back(pix_row(1'b1, 8'd9, 8'd9, 8'd9));
		dir_tbl.push_back(pix_row(1'b0, 8'd0, 8'd0, 8'd0));
		dir_tbl.push_back(pix_row(1'b1, 8'd0, 8'd0, 8'd0));
		dir_tbl.push_back(known_row(1'b1, 8'd0, 8'd0, 8'd0, 8'd128, 8'd128, 8'd128, 1'b0));
		dir_tbl.push_back(known_row(1'b1, 8'd0, 8'd0, 8'd0, 8'd128, 8'd128, 8'd128, 1'b1));
		// full 3x3 frame: every divisor shape from corner to centre
		dir_tbl.push_back(cfg_row(13'd3, 13'd3));
		dir_tbl.push_back(pix_row(1'b0, 8'd255, 8'd0, 8'd1));
		dir_tbl.push_back(pix_row(1'b0, 8'd0, 8'd255, 8'd254));
		dir_tbl.push_back(pix_row(1'b0, 8'd128, 8'd127, 8'd255));
		dir_tbl.push_back(pix_row(1'b0, 8'd1, 8'd2, 8'd3));
		dir_tbl.push_back(pix_row(1'b0, 8'd255, 8'd255, 8'd255));
		dir_tbl.push_back(pix_row(1'b0, 8'd0, 8'd0, 8'd0));
		dir_tbl.push_back(pix_row(1'b0, 8'd200, 8'd100, 8'd50));
		dir_tbl.push_back(pix_row(1'b0, 8'd7, 8'd77, 8'd177));
		dir_tbl.push_back(pix_row(1'b0, 8'd254, 8'd1, 8'd128));
		repeat (4) dir_tbl.push_back(pix_row(1'b1, 8'd0, 8'd0, 8'd0));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table
		foreach (dir_tbl[i]) begin
			if (dir_tbl[i].is_cfg)
				load_geometry(dir_tbl[i].wv, dir_tbl[i].hv);
			else
				offer(dir_tbl[i].m, dir_tbl[i].r, dir_tbl[i].g, dir_tbl[i].b,
					dir_tbl[i].typed, dir_tbl[i].res);
		end

		// random frames, a few at the geometry limits, some cut short
		frame_no = 0;
		plain_items = 0;
		redo = 1;
		while (plain_items < 1300) begin
			frame_no++;
			abort = 0;
			cut = 0;
			special = (frame_no == 2) || (frame_no == 4);
			if (frame_no == 4) begin
				wv = 13'd2047;
				hv = 13'd2;
				redo = 1;
			end else if (frame_no == 2) begin
				wv = 13'd1;
				hv = 13'd8191;
				redo = 1;
			end else if (redo || $urandom_range(0, 2) != 0) begin
				case ($urandom_range(0, 19))
					0: wv[10:0] = 11'd0;
					1: wv[10:0] = 11'($urandom_range(9, 48));
					default: wv[10:0] = 11'($urandom_range(1, 8));
				endcase
				wv[12:11] = 2'($urandom_range(0, 3));
				case ($urandom_range(0, 19))
					0: hv = 13'd0;
					1: hv = 13'($urandom_range(7, 24));
					default: hv = 13'($urandom_range(1, 6));
				endcase
				redo = 1;
			end
			if (redo) load_geometry(wv, hv);
			redo = 0;
			fw = frame_width(wv[WREG_W-1:0]);
			fh = frame_height(hv);
			if (frame_no == 2) begin
				// tall frame cut short while the receiver holds off
				abort = 1;
				cut = 150;
				hold_req = 1;
			end else if (frame_no == 4) begin
				// clamped row width, cut once the first row has begun to come out
				abort = 1;
				cut = 1040;
			end else if (!special && $urandom_range(0, 9) == 0) begin
				abort = 1;
				cut = $urandom_range(0, fw * fh - 1);
			end
			npix = abort ? cut : fw * fh;
			for (int k = 0; k < npix; k++) begin
				if (!calm && $urandom_range(0, 11) == 0) begin
					offer(1'b1, rand_chan(), rand_chan(), rand_chan(), 0, '0);
					plain_items++;
				end
				offer(1'b0, rand_chan(), rand_chan(), rand_chan(), 0, '0);
				plain_items++;
				if (plain_items >= 1050) calm = 1;
			end
			if (abort) begin
				redo = 1;
			end else begin
				// flush the tail; some ticks carry pixel data that must be ignored
				for (int k = 0; k <= fw; k++) begin
					offer($urandom_range(0, 4) != 0, rand_chan(), rand_chan(), rand_chan(), 0, '0);
					plain_items++;
					if (plain_items >= 1050) calm = 1;
				end
			end
		end

		settle();
		repeat (20) @(posedge clk);
		if (fails == 0)
			$display("box_blur_3x3_rgb_unit_tb OK");
		else
			$display("box_blur_3x3_rgb_unit_tb NOT OK");
		$finish;
	end

endmodule
